[src/lfir_pkg.sv]
// Shared types and constants for the long FIR convolution filter.
`default_nettype none

package lfir_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 18;
  localparam int GAIN_W      = 16;
  localparam int TAPS_W      = 11;
  localparam int COEF_IDX_W  = 10;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int CHUNK_W     = 23;
  localparam int CHUNKS      = 3;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 24;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam int MAX_TAPS_DEFAULT = 1024;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd4096;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

  typedef enum logic [0:0] {
    REG_GAIN = 1'b0,
    REG_TAPS = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

[src/lfir_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module lfir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/lfir_mul.sv]
// Shared registered signed multiplier used for taps and gain scaling.
`default_nettype none

module lfir_mul (
  input  wire logic                                clk,
  input  wire logic signed [lfir_pkg::SAMPLE_W-1:0] a,
  input  wire logic signed [lfir_pkg::COEF_W-1:0]   b,
  output logic      signed [lfir_pkg::PROD_W-1:0]   prod
);

  import lfir_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

[src/long_fir_convolution_filter_core.sv]
// Top level of the long FIR convolution filter: sequencer, accumulators, ports.
//
// Input stream (s_*): s_tuser[0] = 0 marks an audio sample, 1 a coefficient load.
// A load writes one coefficient in the accept cycle and yields no result; the
// block stays ready. A sample yields one output sample on the m_* stream.
// Register map on the APB port: 0x0 gain (Q4.12, reset 4096), 0x4 tap count
// (reset 0, zero passes samples straight through). Write only while idle.
// When a sample finishes, s_tready returns in the same cycle as m_tvalid rises, so
// a new sample is taken only after the last one has reached the output register.
// One multiply-accumulate per tap is issued each cycle from the coefficient and
// history RAM read ports, and the pipe then drains; three more passes of the same
// multiplier apply the gain, then the ROUND state rounds and saturates. With a
// tap count of zero the sample goes from accept straight to the output state.
// s_tready stays low while a sample is being worked on.
// The output register holds a result until m_tready; a new item can be taken
// meanwhile, and a finished sample waits in place if the register is still full.
// Reset (rst, synchronous) empties the history, clears the clip flag and the
// output valid flag; coefficients are undefined until loaded. No reset sweep.
`default_nettype none

module long_fir_convolution_filter_core #(
  parameter int MAX_TAPS = lfir_pkg::MAX_TAPS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // s_tdata: sample_in[23:0], coef_index[33:24], coef_value[51:34], zero pad
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [lfir_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser: func[0]
  input  wire logic [0:0]                        s_tuser,
  // m_tdata: sample_out[23:0]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [lfir_pkg::M_TDATA_W-1:0]    m_tdata,
  // m_tuser: clip_warning[0]
  output logic      [0:0]                        m_tuser,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lfir_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [lfir_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [lfir_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  import lfir_pkg::*;

  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int CNT_W = IDX_W + 1;
  localparam int ACC_W = PROD_W + 1 + IDX_W;
  localparam int HI_W  = ACC_W - 2 * CHUNK_W;
  localparam int RES_W = ACC_W + GAIN_W + 1;
  localparam int Y_W   = RES_W - 28;
  localparam logic [RES_W-1:0] RND_HALF = RES_W'(1) << 27;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TAPS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_SCALE = 5'b00100,
    S_ROUND = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;

  logic [GAIN_W-1:0] gain;
  logic [TAPS_W-1:0] tap_count;

  logic [IDX_W-1:0] wp;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] taps_q;
  logic [CNT_W-1:0] k;
  logic [IDX_W-1:0] rd_ptr;
  logic             v1, hv1, v2;
  logic [1:0]       sc, sidx;
  logic             sv1;
  logic             clip_seen;

  logic [ACC_W-1:0]    acc;
  logic [RES_W-1:0]    res;
  logic [SAMPLE_W-1:0] rslt_sample;
  logic                rslt_clip;

  // input fields
  logic [SAMPLE_W-1:0]   in_sample;
  logic [COEF_IDX_W-1:0] in_coef_idx;
  logic [COEF_W-1:0]     in_coef_val;

  assign in_sample   = s_tdata[23:0];
  assign in_coef_idx = s_tdata[33:24];
  assign in_coef_val = s_tdata[51:34];

  logic s_acc, sample_acc, load_acc, coef_we;
  logic issuing, hist_ok, mac_done, sc_issue, scale_done, out_load;
  logic [31:0]      taps_wide;
  logic [CNT_W-1:0] taps_eff;

  assign s_tready   = (state == S_IDLE);
  assign s_acc      = s_tvalid && s_tready;
  assign sample_acc = s_acc && !s_tuser[0];
  assign load_acc   = s_acc && s_tuser[0];
  assign coef_we    = load_acc && (32'(in_coef_idx) < 32'(MAX_TAPS));

  assign taps_wide = (32'(tap_count) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(tap_count);
  assign taps_eff  = taps_wide[CNT_W-1:0];

  assign issuing    = (state == S_MAC) && (k < taps_q);
  assign hist_ok    = k < fill;
  assign mac_done   = (state == S_MAC) && !issuing && !v1 && !v2;
  assign sc_issue   = (state == S_SCALE) && (sc != 2'(CHUNKS));
  assign scale_done = (state == S_SCALE) && (sc == 2'(CHUNKS)) && !sv1;
  assign out_load   = (state == S_OUT) && (!m_tvalid || m_tready);

  // memories
  logic [SAMPLE_W-1:0] hist_rdata;
  logic [COEF_W-1:0]   coef_rdata;

  lfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist (
    .clk   (clk),
    .we    (sample_acc),
    .waddr (wp),
    .wdata (in_sample),
    .raddr (rd_ptr),
    .rdata (hist_rdata)
  );

  lfir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (IDX_W'(in_coef_idx)),
    .wdata (in_coef_val),
    .raddr (k[IDX_W-1:0]),
    .rdata (coef_rdata)
  );

  // shared multiplier: taps during MAC, accumulator chunks times gain in SCALE
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   prod;

  always_comb begin
    if (state == S_SCALE) begin
      case (sc)
        2'd0:    mul_a = {1'b0, acc[CHUNK_W-1:0]};
        2'd1:    mul_a = {1'b0, acc[2*CHUNK_W-1:CHUNK_W]};
        default: mul_a = {{(SAMPLE_W-HI_W){acc[ACC_W-1]}}, acc[ACC_W-1:2*CHUNK_W]};
      endcase
      mul_b = {2'b00, gain};
    end else begin
      mul_a = hv1 ? hist_rdata : '0;
      mul_b = coef_rdata;
    end
  end

  lfir_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  logic [ACC_W-1:0] prod_acc;
  logic [RES_W-1:0] prod_res;
  logic [RES_W-1:0] prod_shifted;

  assign prod_acc = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign prod_res = {{(RES_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    case (sidx)
      2'd0:    prod_shifted = prod_res;
      2'd1:    prod_shifted = prod_res << CHUNK_W;
      default: prod_shifted = prod_res << (2 * CHUNK_W);
    endcase
  end

  // round half up, drop 28 fraction bits, saturate
  logic [RES_W-1:0]    res_rnd;
  logic [Y_W-1:0]      y;
  logic                y_in_range;
  logic [SAMPLE_W-1:0] y_sat;

  assign res_rnd    = res + RND_HALF;
  assign y          = res_rnd[RES_W-1:28];
  assign y_in_range = (y[Y_W-1:SAMPLE_W-1] == '0) || (y[Y_W-1:SAMPLE_W-1] == '1);
  assign y_sat      = y_in_range ? y[SAMPLE_W-1:0] : (y[Y_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gain      <= GAIN_RESET;
      tap_count <= '0;
      wp        <= '0;
      fill      <= '0;
      k         <= '0;
      rd_ptr    <= '0;
      v1        <= 1'b0;
      hv1       <= 1'b0;
      v2        <= 1'b0;
      sc        <= '0;
      sidx      <= '0;
      sv1       <= 1'b0;
      m_tvalid  <= 1'b0;
      clip_seen <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_GAIN: gain      <= pwdata[GAIN_W-1:0];
          REG_TAPS: tap_count <= pwdata[TAPS_W-1:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (sample_acc) begin
            state <= (taps_eff == '0) ? S_OUT : S_MAC;
          end
        end
        S_MAC: begin
          if (mac_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (scale_done) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (sample_acc) begin
        wp     <= (wp == LAST_IDX) ? '0 : wp + 1'b1;
        fill   <= (fill == FULL_CNT) ? fill : fill + 1'b1;
        k      <= '0;
        rd_ptr <= wp;
      end else if (issuing) begin
        k      <= k + 1'b1;
        rd_ptr <= (rd_ptr == '0) ? LAST_IDX : rd_ptr - 1'b1;
      end

      v1  <= issuing;
      hv1 <= issuing && hist_ok;
      v2  <= v1;

      if (mac_done) begin
        sc <= '0;
      end else if (sc_issue) begin
        sc <= sc + 1'b1;
      end
      sv1  <= sc_issue;
      sidx <= sc;

      if (out_load) begin
        m_tvalid <= 1'b1;
        if (rslt_clip) begin
          clip_seen <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      acc         <= '0;
      taps_q      <= taps_eff;
      rslt_sample <= in_sample;
      rslt_clip   <= 1'b0;
    end
    if (v2) begin
      acc <= acc + prod_acc;
    end
    if (mac_done) begin
      res <= '0;
    end else if (sv1) begin
      res <= res + prod_shifted;
    end
    if (state == S_ROUND) begin
      rslt_sample <= y_sat;
      rslt_clip   <= !y_in_range;
    end
    if (out_load) begin
      m_tdata    <= rslt_sample;
      m_tuser[0] <= rslt_clip && !clip_seen;
    end
  end

  // APB read and ready
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_GAIN: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gain};
      REG_TAPS: prdata = {{(APB_DATA_W-TAPS_W){1'b0}}, tap_count};
    endcase
  end

endmodule

`default_nettype wire

[src/lfir_checker.sv]
// Port-level checks for the long FIR convolution filter, bound to the top.
`default_nettype none

module lfir_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [0:0]                     s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [lfir_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [0:0]                     m_tuser
);

  import lfir_pkg::*;

  logic clip_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_done <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser[0]) begin
      clip_done <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // the clip warning fires at most once per reset
  a_clip_once: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !clip_done)
    else $error("second clip warning");

  // a sample transaction makes the block busy
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
    else $error("ready after sample transaction");

  // a coefficient load completes at once
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> s_tready)
    else $error("not ready after load transaction");

endmodule

bind long_fir_convolution_filter_core lfir_checker u_lfir_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
